### sv/obbpq_pkg.sv
// package for the oriented box point query: constants, types, helpers
`default_nettype none
package obbpq_pkg;

  localparam int NumStages  = 18;
  localparam int SqrtFirst  = 9;
  localparam int SqrtStages = NumStages - SqrtFirst;
  localparam int SqrtIters  = 17;
  localparam int SqrtW      = 35;

  typedef enum logic [2:0] {
    REG_CENTER  = 3'd0,
    REG_HALF    = 3'd1,
    REG_AXIS_U  = 3'd2,
    REG_AXIS_V  = 3'd3,
    REG_AXIS_W  = 3'd4,
    REG_VALID   = 3'd5
  } cfg_reg_t;

  localparam logic [47:0] AxisUReset = 48'h0000_0000_4000;
  localparam logic [47:0] AxisVReset = 48'h0000_4000_0000;
  localparam logic [47:0] AxisWReset = 48'h4000_0000_0000;

  typedef struct packed {
    logic [2:0][15:0] pt;
    logic [2:0][15:0] cl;
    logic             is_in;
    logic             nul;
  } carry_t;

  typedef struct packed {
    logic [SqrtW-1:0] n;
    logic [SqrtW-1:0] r;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, int iter);
    logic [SqrtW-1:0] bitv;
    logic [SqrtW-1:0] trial;
    sqrt_t            o;
    bitv  = SqrtW'(1) << (32 - 2 * iter);
    trial = s.r + bitv;
    if (s.n >= trial) begin
      o.n = s.n - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [15:0] sat16(logic signed [22:0] x);
    logic [15:0] o;
    if (x > 23'sd32767) begin
      o = 16'h7fff;
    end else if (x < -23'sd32768) begin
      o = 16'h8000;
    end else begin
      o = x[15:0];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### sv/obb_point_query.sv
// top level of the oriented box point query pipeline
//
// Accepts one query point per cycle unless stalled and returns the inside flag,
// closest box point and floored distance in Q9.8. Nine arithmetic stages
// (offset, axis products, dot sums, clamp, back-rotation products, sums,
// rounding and saturation, squares, squared distance) feed a nine-stage
// square root giving two result bits per stage, one in the last. A stage
// holds while the next is full and stalled, so bubbles close up and a full
// pipeline keeps one transaction per cycle unless stalled. Write registers
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none
module obb_point_query import obbpq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        point_valid,
  output logic             point_stall,
  input  wire logic [15:0] point_x,
  input  wire logic [15:0] point_y,
  input  wire logic [15:0] point_z,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             inside_res,
  output logic [15:0]      closest_x,
  output logic [15:0]      closest_y,
  output logic [15:0]      closest_z,
  output logic [16:0]      distance,
  output logic             distance_valid
);

  logic [47:0] center;
  logic [47:0] half;
  logic [2:0][47:0] axis;
  logic        box_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      center    <= '0;
      half      <= '0;
      axis[0]   <= AxisUReset;
      axis[1]   <= AxisVReset;
      axis[2]   <= AxisWReset;
      box_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER: center    <= cfg_data;
        REG_HALF:   half      <= cfg_data;
        REG_AXIS_U: axis[0]   <= cfg_data;
        REG_AXIS_V: axis[1]   <= cfg_data;
        REG_AXIS_W: axis[2]   <= cfg_data;
        REG_VALID:  box_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NumStages-1:0] v;
  logic [NumStages-1:0] en;
  carry_t               cy [NumStages];
  carry_t               cy0_in;
  carry_t               cy3_in;
  carry_t               cy6_in;

  always_comb begin
    en[NumStages-1] = !v[NumStages-1] || !result_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign point_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= point_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: offset from center
  logic signed [2:0][16:0] d0;
  always_comb begin
    cy0_in.pt    = {point_z, point_y, point_x};
    cy0_in.cl    = '0;
    cy0_in.is_in = 1'b0;
    cy0_in.nul   = !box_valid;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0[0] <= $signed({point_x[15], point_x}) - $signed({center[15], center[15:0]});
      d0[1] <= $signed({point_y[15], point_y}) - $signed({center[31], center[31:16]});
      d0[2] <= $signed({point_z[15], point_z}) - $signed({center[47], center[47:32]});
    end
  end

  // stage 1: products d_i * a_k_i
  logic signed [32:0] pr1 [3][3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr1[k][i] <= $signed(d0[i]) * $signed(axis[k][16*i +: 16]);
        end
      end
    end
  end

  // stage 2: local coordinates
  logic signed [34:0] lc [3];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        lc[k] <= 35'(pr1[k][0]) + 35'(pr1[k][1]) + 35'(pr1[k][2]);
      end
    end
  end

  // stage 3: clamp to half extents
  logic signed [31:0] qc [3];
  logic signed [34:0] ext [3];
  logic [2:0]         in_k;
  logic signed [34:0] qn [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext[k]  = $signed({5'b0, half[16*k +: 16], 14'b0});
      in_k[k] = (lc[k] <= ext[k]) && (lc[k] >= -ext[k]);
      if (lc[k] > ext[k]) begin
        qn[k] = ext[k];
      end else if (lc[k] < -ext[k]) begin
        qn[k] = -ext[k];
      end else begin
        qn[k] = lc[k];
      end
    end
    cy3_in       = cy[2];
    cy3_in.is_in = &in_k;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        qc[k] <= qn[k][31:0];
      end
    end
  end

  // stage 4: products q_k * a_k_i
  logic signed [47:0] pr2 [3][3];
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pr2[i][k] <= qc[k] * $signed(axis[k][16*i +: 16]);
        end
      end
    end
  end

  // stage 5: world offsets
  logic signed [49:0] ow [3];
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        ow[i] <= 50'(pr2[i][0]) + 50'(pr2[i][1]) + 50'(pr2[i][2]);
      end
    end
  end

  // stage 6: round, add center, saturate; inside points or a null box keep the point
  logic signed [49:0] orr [3];
  logic signed [22:0] csum [3];
  always_comb begin
    cy6_in = cy[5];
    for (int i = 0; i < 3; i++) begin
      orr[i]  = ow[i] + 50'sd134217728;
      csum[i] = 23'($signed(center[16*i +: 16])) + 23'($signed(orr[i][49:28]));
      cy6_in.cl[i] = (cy[5].is_in || cy[5].nul) ? cy[5].pt[i] : sat16(csum[i]);
    end
  end

  // carried point, closest point and flags
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cy[0] <= cy0_in;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        if (k == 3) begin
          cy[k] <= cy3_in;
        end else if (k == 6) begin
          cy[k] <= cy6_in;
        end else begin
          cy[k] <= cy[k-1];
        end
      end
    end
  end

  // stage 7: squared differences
  logic signed [16:0] df [3];
  logic signed [33:0] sqf [3];
  logic [31:0]        sq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i]  = $signed({cy[6].cl[i][15], cy[6].cl[i]})
             - $signed({cy[6].pt[i][15], cy[6].pt[i]});
      sqf[i] = df[i] * df[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= sqf[i][31:0];
      end
    end
  end

  // stage 8: squared distance
  logic [33:0] dsq;
  always_ff @(posedge clk) begin
    if (en[8]) begin
      dsq <= 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
    end
  end

  // stages 9 to 17: square root, two bits per stage, one in the last
  sqrt_t sr [SqrtStages];
  genvar m;
  generate
    for (m = 0; m < SqrtStages; m++) begin : g_sqrt
      sqrt_t sin;
      sqrt_t smid;
      sqrt_t sout;
      if (m == 0) begin : g_first
        assign sin.n = SqrtW'(dsq);
        assign sin.r = '0;
      end else begin : g_rest
        assign sin = sr[m-1];
      end
      assign smid = sqrt_step(sin, 2 * m);
      if (2 * m + 1 < SqrtIters) begin : g_two
        assign sout = sqrt_step(smid, 2 * m + 1);
      end else begin : g_one
        assign sout = smid;
      end
      always_ff @(posedge clk) begin
        if (en[SqrtFirst + m]) begin
          sr[m] <= sout;
        end
      end
    end
  endgenerate

  assign result_valid   = v[NumStages-1];
  assign inside_res     = cy[NumStages-1].is_in && !cy[NumStages-1].nul;
  assign closest_x      = cy[NumStages-1].cl[0];
  assign closest_y      = cy[NumStages-1].cl[1];
  assign closest_z      = cy[NumStages-1].cl[2];
  assign distance       = sr[SqrtStages-1].r[16:0];
  assign distance_valid = !cy[NumStages-1].nul;

endmodule
`default_nettype wire

### sim/tb_obb_point_query.sv
// testbench for the oriented box point query: random and directed points
`default_nettype none
module tb_obb_point_query;
  import obbpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        is_in;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [16:0] dlen;
    logic        dvalid;
  } query_ans_t;

  class query_board;
    logic [47:0] center, half, axu, axv, axw;
    logic        valid_box;
    query_ans_t  pending[$];
    int          errors;

    function void reset_regs();
      center = '0; half = '0;
      axu = AxisUReset; axv = AxisVReset; axw = AxisWReset;
      valid_box = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [47:0] v);
      case (idx)
        REG_CENTER: center = v;
        REG_HALF:   half = v;
        REG_AXIS_U: axu = v;
        REG_AXIS_V: axv = v;
        REG_AXIS_W: axw = v;
        REG_VALID:  valid_box = v[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
      longint p[3], d[3], lc[3], q[3], cl[3], c[3], e, o, df;
      longint ax[3][3];
      logic [47:0] axr[3];
      longint unsigned sum;
      bit in_box;
      query_ans_t a;
      axr[0] = axu; axr[1] = axv; axr[2] = axw;
      p[0] = longint'($signed(px)); p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      for (int i = 0; i < 3; i++) begin
        c[i] = longint'($signed(center[16*i +: 16]));
        d[i] = p[i] - c[i];
        for (int k = 0; k < 3; k++) ax[k][i] = longint'($signed(axr[k][16*i +: 16]));
      end
      in_box = 1;
      sum = 0;
      if (!valid_box) begin
        a.is_in = 0; a.cx = px; a.cy = py; a.cz = pz; a.dlen = '0; a.dvalid = 0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          e = longint'(half[16*k +: 16]) * 16384;
          lc[k] = d[0] * ax[k][0] + d[1] * ax[k][1] + d[2] * ax[k][2];
          q[k] = lc[k];
          if (q[k] > e) begin q[k] = e; in_box = 0; end
          if (q[k] < -e) begin q[k] = -e; in_box = 0; end
        end
        for (int i = 0; i < 3; i++) begin
          if (in_box) begin
            cl[i] = p[i];
          end else begin
            o = q[0] * ax[0][i] + q[1] * ax[1][i] + q[2] * ax[2][i];
            o = (o + (longint'(1) << 27)) >>> 28;
            cl[i] = c[i] + o;
            if (cl[i] > 32767) cl[i] = 32767;
            if (cl[i] < -32768) cl[i] = -32768;
          end
          df = cl[i] - p[i];
          sum += longint'(df * df);
        end
        a.is_in = in_box;
        a.cx = cl[0][15:0]; a.cy = cl[1][15:0]; a.cz = cl[2][15:0];
        a.dlen = in_box ? 17'd0 : 17'(root_floor(sum));
        a.dvalid = 1;
      end
      pending = {pending, a};
    endfunction

    function void check_result(query_ans_t got);
      query_ans_t w;
      if (pending.size() == 0) begin
        $display("%0t unexpected result transaction", $time);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.is_in !== w.is_in || got.cx !== w.cx || got.cy !== w.cy ||
          got.cz !== w.cz || got.dlen !== w.dlen || got.dvalid !== w.dvalid) begin
        $display({"%0t mismatch: expected in=%0b c=%h,%h,%h d=%0d dv=%0b",
                  " actual in=%0b c=%h,%h,%h d=%0d dv=%0b"},
                 $time, w.is_in, w.cx, w.cy, w.cz, w.dlen, w.dvalid,
                 got.is_in, got.cx, got.cy, got.cz, got.dlen, got.dvalid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic point_valid = 0, result_stall = 0;
  logic [15:0] point_x = '0, point_y = '0, point_z = '0;
  logic point_stall, result_valid, inside_res, distance_valid;
  logic [15:0] closest_x, closest_y, closest_z;
  logic [16:0] distance;
  bit no_idle = 0;
  bit stim_done = 0;
  query_board board;

  obb_point_query dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL obb_point_query");
    $finish;
  end

  always @(posedge clk) begin
    query_ans_t g;
    if (!rst && result_valid && !result_stall) begin
      g.is_in = inside_res; g.cx = closest_x; g.cy = closest_y; g.cz = closest_z;
      g.dlen = distance; g.dvalid = distance_valid;
      board.check_result(g);
    end
  end

  initial begin
    int n;
    while (!stim_done) begin
      @(negedge clk);
      if (no_idle) begin
        result_stall <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        result_stall <= 1;
        repeat (n) @(negedge clk);
        result_stall <= 0;
      end
    end
    result_stall <= 0;
  end

  task automatic write_reg(cfg_reg_t idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      point_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    point_valid <= 1; point_x <= x; point_y <= y; point_z <= z;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    board.note_point(x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    point_valid <= 0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic logic [47:0] rnd_axis_set(int sel);
    logic [15:0] a, b;
    a = 16'($urandom_range(0, 16384));
    b = 16'($rtoi($sqrt(268435456.0 - real'(a) * real'(a))));
    if ($urandom_range(0, 1)) b = -b;
    case (sel)
      0: return {16'h0, b, a};
      1: return {a, 16'h0, b};
      default: return {b, a, 16'h0};
    endcase
  endfunction

  initial begin
    logic [15:0] ext[4];
    board = new();
    board.reset_regs();
    board.errors = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // null box at reset
    send_point(16'h7fff, 16'h8000, 16'h0000);
    send_point(16'h1234, 16'hffff, 16'h8001);
    drain();
    write_reg(REG_VALID, 48'h1);
    write_reg(REG_HALF, {16'h0200, 16'h0100, 16'h0300});
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0300, 16'h0100, 16'h0200);
    send_point(16'h0301, 16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7fff, 16'h0001);
    drain();
    write_reg(REG_CENTER, {16'h7f00, 16'h8100, 16'h7fff});
    write_reg(REG_HALF, 48'hffff_ffff_ffff);
    write_reg(REG_AXIS_U, 48'h8000_8000_8000);
    write_reg(REG_AXIS_V, 48'h7fff_7fff_7fff);
    write_reg(REG_AXIS_W, 48'h0000_c000_4000);
    send_point(16'h7fff, 16'h8000, 16'h7fff);
    send_point(16'h8000, 16'h7fff, 16'h8000);
    send_point(16'h0000, 16'hffff, 16'h5555);
    send_point(16'haaaa, 16'h5555, 16'h0000);
    drain();
    write_reg(REG_HALF, 48'h0);
    send_point(16'h7fff, 16'h7fff, 16'h8000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_VALID, 48'hffff_ffff_fffe);
    send_point(16'h0101, 16'h0202, 16'h0303);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 10) no_idle = 1;
      if (ph % 3 == 0) begin
        write_reg(REG_AXIS_U, AxisUReset);
        write_reg(REG_AXIS_V, AxisVReset);
        write_reg(REG_AXIS_W, AxisWReset);
      end else if (ph % 3 == 1) begin
        write_reg(REG_AXIS_U, rnd_axis_set(0));
        write_reg(REG_AXIS_V, rnd_axis_set(1));
        write_reg(REG_AXIS_W, rnd_axis_set(2));
      end else begin
        write_reg(REG_AXIS_U, 48'({$urandom(), $urandom()}));
        write_reg(REG_AXIS_V, 48'({$urandom(), $urandom()}));
        write_reg(REG_AXIS_W, 48'({$urandom(), $urandom()}));
      end
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: ext[k] = 16'($urandom_range(0, 65535));
          1: ext[k] = 16'h0000;
          2: ext[k] = 16'hffff;
          default: ext[k] = 16'($urandom_range(0, 2048));
        endcase
      end
      write_reg(REG_HALF, {ext[2], ext[1], ext[0]});
      write_reg(REG_CENTER, {rnd_coord(), rnd_coord(), rnd_coord()});
      write_reg(REG_VALID, (ph == 4) ? 48'h0 : 48'h1);
      if ($urandom_range(0, 1)) write_reg(cfg_reg_t'(3'd6 + $urandom_range(0, 1)),
                                          48'({$urandom(), $urandom()}));
      for (int n = 0; n < 150; n++)
        send_point(rnd_coord(), rnd_coord(), rnd_coord());
      drain();
    end
    stim_done = 1;

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS obb_point_query");
    end else begin
      if (board.pending.size() != 0)
        $display("%0t %0d expected results never arrived", $time, board.pending.size());
      $display("FAIL obb_point_query");
    end
    $finish;
  end
endmodule
`default_nettype wire
